@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/i2ctrf_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C target register file package
// Response codes, result layout and default sizes for the register file unit.
// ----------------------------------------------------------------------------
package i2ctrf_pkg;

    localparam int DEFAULT_BANK_DEPTH = 16;
    localparam int IN_TDATA_W         = 8;
    localparam int IN_TUSER_W         = 5;
    localparam int OUT_TDATA_W        = 24;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;

    typedef enum logic [1:0] {
        RESP_NONE = 2'd0,
        RESP_ACK  = 2'd1,
        RESP_NACK = 2'd2
    } resp_t;

    // Packed from the lowest bit up: response, load_count, first_load,
    // second_load, busy_res, fault_seen.
    typedef struct packed {
        logic       fault_seen;
        logic       busy_res;
        logic [7:0] second_load;
        logic [7:0] first_load;
        logic [1:0] load_count;
        resp_t      response;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

@@ hw/rtl/i2ctrf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module i2ctrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ hw/rtl/i2c_target_register_file_unit.sv @@
// ----------------------------------------------------------------------------
// I2C target register file unit
// Event-level I2C target with a pointer-addressed byte register bank.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Fields (lowest bit up)
// s_*      in         tuser: bus_fault, address_match, byte_received,
//                     master_acked, stop_seen; tdata: data_byte
// m_*      out        tdata: response, load_count, first_load, second_load,
//                     busy_res, fault_seen
//
// One event is taken per cycle while s_tready is high; its result is registered.
// A pointer byte that arrives together with a master ack is held as pending,
// because the bank byte at the new pointer is read from the RAM port first.
// The bank RAM is read ahead at the pointer and the entry after it.
// Reset clears the control and valid state at once; bank entries read as zero until written.
// A two-entry output stage keeps input flowing while a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_target_register_file_unit #(
    parameter int BANK_DEPTH = i2ctrf_pkg::DEFAULT_BANK_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2ctrf_pkg::IN_TDATA_W-1:0]  s_tdata,  // data_byte
    input  logic [i2ctrf_pkg::IN_TUSER_W-1:0]  s_tuser,  // bus_fault, address_match,
                                                         // byte_received, master_acked,
                                                         // stop_seen
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2ctrf_pkg::OUT_TDATA_W-1:0] m_tdata   // response, load_count,
                                                         // first_load, second_load,
                                                         // busy_res, fault_seen
);

    import i2ctrf_pkg::*;

    localparam int PW = $clog2(BANK_DEPTH + 1);
    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(BANK_DEPTH);

    logic [PW-1:0] ptr_reg, ptr_next;
    logic          prx_reg, prx_next;
    logic          busy_reg, busy_next;
    logic          fault_reg, fault_next;
    logic          pend_reg, pend_next;
    result_t       pend_res_reg, pend_res_next;
    logic          vld_reg [BANK_DEPTH];
    logic          rv0_reg, rv1_reg;
    result_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    result_t       skid_reg, skid_next;
    logic          skid_valid_reg, skid_valid_next;

    logic          flt, adr, rxv, ack, stp;
    logic [7:0]    d;
    logic          accept, pop, push;
    result_t       res;

    logic [7:0]    rd0, rd1, cur0, cur1, ack_val;
    logic [PW:0]   ptr1, nx1;
    logic [PW-1:0] ptr_inc;
    logic          ptr_ok, ptr1_ok, d_ok;
    logic          adv, defer;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;

    assign flt = s_tuser[0];
    assign adr = s_tuser[1];
    assign rxv = s_tuser[2];
    assign ack = s_tuser[3];
    assign stp = s_tuser[4];
    assign d   = s_tdata;

    assign s_tready = !skid_valid_reg && !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_reg};

    assign cur0    = rv0_reg ? rd0 : 8'h00;
    assign cur1    = rv1_reg ? rd1 : 8'h00;
    assign ptr1    = {1'b0, ptr_reg} + 1'b1;
    assign ptr_inc = ptr1[PW-1:0];
    assign ptr_ok  = 9'(ptr_reg) < DEPTH_LIM;
    assign ptr1_ok = 9'(ptr1) < DEPTH_LIM;
    assign d_ok    = {1'b0, d} < DEPTH_LIM;
    assign wr_addr = ptr_reg[AW-1:0];

    always_comb
    begin
        ptr_next      = ptr_reg;
        prx_next      = prx_reg;
        busy_next     = busy_reg;
        fault_next    = fault_reg;
        pend_next     = pend_reg;
        pend_res_next = pend_res_reg;
        wr_en         = 1'b0;
        push          = 1'b0;
        adv           = 1'b0;
        defer         = 1'b0;
        ack_val       = FILL_BYTE;
        res           = '0;
        if (pend_reg)
        begin
            if (!skid_valid_reg)
            begin
                push           = 1'b1;
                pend_next      = 1'b0;
                res            = pend_res_reg;
                res.load_count = 2'd1;
                res.first_load = ptr_ok ? cur0 : FILL_BYTE;
                if (ptr_ok)
                begin
                    ptr_next = ptr_inc;
                end
            end
        end
        else if (accept)
        begin
            if (flt)
            begin
                busy_next  = 1'b0;
                fault_next = 1'b1;
            end
            else
            begin
                if (adr)
                begin
                    res.response = RESP_ACK;
                    busy_next    = 1'b1;
                    if (d[0])
                    begin
                        res.load_count = 2'd1;
                        res.first_load = ptr_ok ? cur0 : FILL_BYTE;
                        if (ptr_ok)
                        begin
                            adv      = 1'b1;
                            ptr_next = ptr_inc;
                        end
                    end
                    else
                    begin
                        prx_next = 1'b0;
                    end
                end
                else if (rxv)
                begin
                    if (!prx_reg)
                    begin
                        if (d_ok)
                        begin
                            ptr_next     = d[PW-1:0];
                            prx_next     = 1'b1;
                            res.response = RESP_ACK;
                            defer        = 1'b1;
                        end
                        else
                        begin
                            res.response = RESP_NACK;
                        end
                    end
                    else if (ptr_ok)
                    begin
                        wr_en        = 1'b1;
                        ptr_next     = ptr_inc;
                        adv          = 1'b1;
                        res.response = RESP_ACK;
                    end
                    else
                    begin
                        res.response = RESP_NACK;
                    end
                end
                if (ack && !defer)
                begin
                    if (adv)
                    begin
                        ack_val = ptr1_ok ? cur1 : FILL_BYTE;
                        if (ptr1_ok)
                        begin
                            ptr_next = PW'(ptr1 + 1'b1);
                        end
                    end
                    else
                    begin
                        ack_val = ptr_ok ? cur0 : FILL_BYTE;
                        if (ptr_ok)
                        begin
                            ptr_next = ptr_inc;
                        end
                    end
                    if (res.load_count == 2'd0)
                    begin
                        res.first_load = ack_val;
                    end
                    else
                    begin
                        res.second_load = ack_val;
                    end
                    res.load_count = res.load_count + 2'd1;
                end
                if (stp)
                begin
                    busy_next = 1'b0;
                end
            end
            res.busy_res   = busy_next;
            res.fault_seen = fault_next;
            if (ack && defer && !flt)
            begin
                pend_next     = 1'b1;
                pend_res_next = res;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    // The bank is read ahead at the next pointer and the entry after it.
    assign nx1      = {1'b0, ptr_next} + 1'b1;
    assign rd_addr0 = (9'(ptr_next) < DEPTH_LIM) ? ptr_next[AW-1:0] : '0;
    assign rd_addr1 = (9'(nx1) < DEPTH_LIM) ? nx1[AW-1:0] : '0;

    i2ctrf_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (d),
        .rd_addr_a (rd_addr0),
        .rd_data_a (rd0),
        .rd_addr_b (rd_addr1),
        .rd_data_b (rd1)
    );

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            prx_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            fault_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            rv0_reg        <= 1'b0;
            rv1_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < BANK_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            ptr_reg        <= ptr_next;
            prx_reg        <= prx_next;
            busy_reg       <= busy_next;
            fault_reg      <= fault_next;
            pend_reg       <= pend_next;
            rv0_reg        <= vld_reg[rd_addr0];
            rv1_reg        <= vld_reg[rd_addr1];
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_res_reg <= pend_res_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

    `ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `ASSERT_SAME(a_pend_blocks_input, pend_reg, !s_tready, "input taken during deferred load")
    `ASSERT_NEXT(a_fault_sticky, fault_reg, fault_reg, "fault mark cleared")
    `ASSERT_SAME(a_two_loads_acked, out_valid_reg && out_reg.load_count == 2'd2, out_reg.response == RESP_ACK, "two loads without ack")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// I2C target register file unit testbench
// Drives bus event transactions into the unit and checks every result against
// a cycle-free model of the register bank, its pointer and its status flags,
// or against the fixed results of a short directed table, which comes first;
// then randomized write, read and combined transfers mixed with malformed
// events, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import i2ctrf_pkg::*;

    localparam int BANK_DEPTH    = DEFAULT_BANK_DEPTH;
    localparam int RANDOM_EVENTS = 1300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int TAIL_CYCLES   = 20;

    localparam logic [4:0] EV_NONE  = 5'b00000;
    localparam logic [4:0] EV_FAULT = 5'b00001;
    localparam logic [4:0] EV_ADDR  = 5'b00010;
    localparam logic [4:0] EV_RX    = 5'b00100;
    localparam logic [4:0] EV_MACK  = 5'b01000;
    localparam logic [4:0] EV_STOP  = 5'b10000;
    localparam logic [4:0] EV_ALL   = 5'b11111;

    typedef struct packed {
        logic [4:0] flags;
        logic [7:0] data;
    } bus_event_t;

    typedef struct packed {
        bus_event_t ev;
        logic       fixed;
        result_t    res;
    } stim_row_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [7:0] bank_model [BANK_DEPTH];
    logic [4:0] pointer_model;
    logic       pointer_set;
    logic       busy_model;
    logic       fault_model;

    stim_row_t stim_q [$];
    result_t   result_q [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int directed_count = 0;
    int nack_count     = 0;
    int fill_count     = 0;
    int fault_count    = 0;

    i2c_target_register_file_unit #(
        .BANK_DEPTH(BANK_DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t result_of(resp_t resp, logic [1:0] count, logic [7:0] first,
                                          logic [7:0] second, logic busy, logic fault);
        result_t r;
        r.response    = resp;
        r.load_count  = count;
        r.first_load  = first;
        r.second_load = second;
        r.busy_res    = busy;
        r.fault_seen  = fault;
        return r;
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] value;
        if (pointer_model < BANK_DEPTH)
        begin
            value         = bank_model[pointer_model];
            pointer_model = pointer_model + 5'd1;
        end
        else
        begin
            value = FILL_BYTE;
            fill_count++;
        end
        return value;
    endfunction

    function automatic result_t predict_event(bus_event_t ev);
        logic [7:0] loaded [2];
        resp_t      resp;
        int         count;
        loaded[0] = 8'h00;
        loaded[1] = 8'h00;
        resp      = RESP_NONE;
        count     = 0;
        if ((ev.flags & EV_FAULT) != 0)
        begin
            busy_model  = 1'b0;
            fault_model = 1'b1;
            fault_count++;
        end
        else
        begin
            if ((ev.flags & EV_ADDR) != 0)
            begin
                resp       = RESP_ACK;
                busy_model = 1'b1;
                if (ev.data[0])
                begin
                    loaded[count] = fetch_byte();
                    count++;
                end
                else
                    pointer_set = 1'b0;
            end
            else if ((ev.flags & EV_RX) != 0)
            begin
                if (!pointer_set)
                begin
                    if (ev.data < BANK_DEPTH)
                    begin
                        pointer_model = ev.data[4:0];
                        pointer_set   = 1'b1;
                        resp          = RESP_ACK;
                    end
                    else
                        resp = RESP_NACK;
                end
                else if (pointer_model < BANK_DEPTH)
                begin
                    bank_model[pointer_model] = ev.data;
                    pointer_model             = pointer_model + 5'd1;
                    resp                      = RESP_ACK;
                end
                else
                    resp = RESP_NACK;
            end
            if ((ev.flags & EV_MACK) != 0)
            begin
                loaded[count] = fetch_byte();
                count++;
            end
            if ((ev.flags & EV_STOP) != 0)
                busy_model = 1'b0;
        end
        if (resp == RESP_NACK)
            nack_count++;
        return result_of(resp, 2'(count), loaded[0], loaded[1], busy_model, fault_model);
    endfunction

    function automatic bit same_result(result_t a, result_t b);
        return (a.response === b.response) && (a.load_count === b.load_count) &&
               (a.first_load === b.first_load) && (a.second_load === b.second_load) &&
               (a.busy_res === b.busy_res) && (a.fault_seen === b.fault_seen);
    endfunction

    task automatic report_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("Mismatch at result %0d (%s): expected resp=%0d loads=%0d first=%02h %s",
                     results_seen, what, want.response, want.load_count, want.first_load,
                     $sformatf("second=%02h busy=%0b fault=%0b",
                               want.second_load, want.busy_res, want.fault_seen));
            $display("    actual resp=%0d loads=%0d first=%02h second=%02h busy=%0b fault=%0b",
                     got.response, got.load_count, got.first_load, got.second_load,
                     got.busy_res, got.fault_seen);
        end
    endtask

    task automatic add_row(logic [4:0] flags, logic [7:0] data, logic fixed, result_t res);
        stim_row_t row;
        row.ev.flags = flags;
        row.ev.data  = data;
        row.fixed    = fixed;
        row.res      = res;
        stim_q.push_back(row);
    endtask

    task automatic add_event(logic [4:0] flags, logic [7:0] data);
        logic [4:0] f;
        f = flags;
        if ($urandom_range(0, 49) == 0)
            f = f | EV_FAULT;
        add_row(f, data, 1'b0, '0);
    endtask

    task automatic gen_traffic(int count);
        int         kind;
        int         n;
        int         k;
        int         start;
        logic [6:0] addr7;
        logic [7:0] ptr;
        logic [4:0] noise;
        start = stim_q.size();
        while (stim_q.size() - start < count)
        begin
            kind  = $urandom_range(0, 99);
            addr7 = 7'($urandom);
            if (kind < 55)
            begin
                add_event(($urandom_range(0, 9) == 0) ? (EV_ADDR | EV_RX) : EV_ADDR,
                          {addr7, 1'b0});
                ptr = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(BANK_DEPTH, 255))
                                                  : 8'($urandom_range(0, BANK_DEPTH - 1));
                add_event(($urandom_range(0, 6) == 0) ? (EV_RX | EV_MACK) : EV_RX, ptr);
                n = $urandom_range(0, 8);
                if (kind < 40)
                begin
                    for (k = 0; k < n; k++)
                        add_event(EV_RX, 8'($urandom));
                end
                else
                begin
                    add_event(EV_ADDR, {addr7, 1'b1});
                    for (k = 0; k < n; k++)
                        add_event(EV_MACK, 8'($urandom));
                end
            end
            else if (kind < 85)
            begin
                add_event(($urandom_range(0, 4) == 0) ? (EV_ADDR | EV_MACK) : EV_ADDR,
                          {addr7, 1'b1});
                n = $urandom_range(0, 10);
                for (k = 0; k < n; k++)
                    add_event(EV_MACK, 8'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                begin
                    noise = 5'($urandom);
                    if ((noise & EV_FAULT) != 0 && $urandom_range(0, 3) != 0)
                        noise = noise & ~EV_FAULT;
                    add_event(noise, 8'($urandom));
                end
            end
            if (kind < 85 && $urandom_range(0, 9) != 0)
                add_event(($urandom_range(0, 2) == 0) ? (EV_STOP | EV_MACK) : EV_STOP,
                          8'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, result_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            results_seen++;
            if (result_q.size() == 0)
                report_mismatch("no transaction pending", '0, got);
            else
            begin
                want = result_q.pop_front();
                if (!same_result(want, got))
                    report_mismatch("field mismatch", want, got);
            end
        end
    end

    initial
    begin
        int stall;
        bit held;
        held = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 400)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = (results_seen % 300 < 50) ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        stim_row_t row;
        result_t   want;
        int        gap;
        bit        pause;
        int        idx;

        for (idx = 0; idx < BANK_DEPTH; idx++)
            bank_model[idx] = 8'h00;
        pointer_model = 5'd0;
        pointer_set   = 1'b0;
        busy_model    = 1'b0;
        fault_model   = 1'b0;

        add_row(EV_ADDR, 8'hA1, 1'b1, result_of(RESP_ACK, 2'd1, 8'h00, 8'h00, 1'b1, 1'b0));
        add_row(EV_MACK, 8'h00, 1'b1, result_of(RESP_NONE, 2'd1, 8'h00, 8'h00, 1'b1, 1'b0));
        add_row(EV_STOP, 8'h00, 1'b1, result_of(RESP_NONE, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0));
        add_row(EV_ADDR, 8'hA0, 1'b1, result_of(RESP_ACK, 2'd0, 8'h00, 8'h00, 1'b1, 1'b0));
        add_row(EV_RX, 8'h0F, 1'b0, '0);
        add_row(EV_RX, 8'hFF, 1'b0, '0);
        add_row(EV_RX, 8'h00, 1'b1, result_of(RESP_NACK, 2'd0, 8'h00, 8'h00, 1'b1, 1'b0));
        add_row(EV_STOP, 8'h00, 1'b0, '0);
        add_row(EV_ADDR, 8'hFE, 1'b0, '0);
        add_row(EV_RX, 8'h10, 1'b1, result_of(RESP_NACK, 2'd0, 8'h00, 8'h00, 1'b1, 1'b0));
        add_row(EV_RX, 8'hFF, 1'b1, result_of(RESP_NACK, 2'd0, 8'h00, 8'h00, 1'b1, 1'b0));
        add_row(EV_RX, 8'h00, 1'b0, '0);
        add_row(EV_RX, 8'h5A, 1'b0, '0);
        add_row(EV_RX | EV_STOP, 8'hA5, 1'b0, '0);
        add_row(EV_ADDR | EV_MACK, 8'h01, 1'b0, '0);
        add_row(EV_ADDR | EV_RX, 8'h00, 1'b0, '0);
        add_row(EV_RX | EV_MACK, 8'h00, 1'b0, '0);
        add_row(EV_ADDR, 8'h00, 1'b0, '0);
        add_row(EV_RX, 8'h0F, 1'b0, '0);
        add_row(EV_ADDR, 8'h01, 1'b0, '0);
        add_row(EV_MACK, 8'h00, 1'b1, result_of(RESP_NONE, 2'd1, FILL_BYTE, 8'h00, 1'b1, 1'b0));
        add_row(EV_ADDR | EV_MACK, 8'hFF, 1'b1,
                result_of(RESP_ACK, 2'd2, FILL_BYTE, FILL_BYTE, 1'b1, 1'b0));
        add_row(EV_ALL, 8'hFF, 1'b1, result_of(RESP_NONE, 2'd0, 8'h00, 8'h00, 1'b0, 1'b1));
        add_row(EV_NONE, 8'h00, 1'b1, result_of(RESP_NONE, 2'd0, 8'h00, 8'h00, 1'b0, 1'b1));
        add_row(EV_ADDR | EV_RX | EV_MACK | EV_STOP, 8'hFF, 1'b0, '0);
        directed_count = stim_q.size();
        gen_traffic(RANDOM_EVENTS);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_q.size(); i++)
        begin
            row   = stim_q[i];
            pause = (i == directed_count + 800);
            gap   = (i % 250 < 40) ? 0 : $urandom_range(0, 18);
            if (pause)
                gap = gap + 1;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                if (pause)
                    while (result_q.size() != 0)
                        @(posedge clk);
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= row.ev.flags;
            s_tdata  <= row.ev.data;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            want = predict_event(row.ev);
            result_q.push_back(row.fixed ? row.res : want);
        end
        s_tvalid <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d bus events (%0d directed) and %0d results, %0d mismatches.",
                 stim_q.size(), directed_count, results_seen, mismatch_count);
        $display("It saw %0d nacks, %0d fill-byte loads and %0d bus faults under backpressure.",
                 nack_count, fill_count, fault_count);
        if (mismatch_count == 0 && result_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
